FILE: src/fcsd_pkg.sv
`timescale 1ns / 1ps

package fcsd_pkg;

	// Readout snapshot: two bytes for each of up to four channels.
	localparam int MAX_CHANNELS = 4;
	localparam int SNAP_BYTES   = 8;
	localparam int SNAP_IDX_W   = $clog2(SNAP_BYTES);
	localparam int SNAP_W       = SNAP_BYTES * 8;
	localparam int SEND_IDX_W   = 8;

	localparam logic [7:0] STOP_BYTE = 8'hFF;

	// Counter reset values step by this pattern: channel c starts at (c + 1) times it.
	localparam logic [31:0] COUNT_RST_STEP = 32'h0000_1111;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 16;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       byte_done;
		logic       select_n;
		logic [3:0] dir_lines;
		logic [3:0] step_lines;
	} in_item_t;

	typedef struct packed {
		logic       busy_res;
		logic [7:0] tx_byte;
		logic       tx_load;
	} rdo_res_t;

endpackage

FILE: src/four_channel_step_dir_counter_readout.sv
`timescale 1ns / 1ps

// Channel  | Dir | Signals                        | Contents of tdata, lowest bit up
// ---------+-----+--------------------------------+------------------------------------------
// s_axis   | in  | s_axis_tvalid/tready/tdata[23:0] | step_lines[3:0], dir_lines[3:0],
//          |     |                                  | select_n, byte_done, rx_byte[7:0], 0s
// m_axis   | out | m_axis_tvalid/tready/tdata[15:0] | tx_load, tx_byte[7:0], busy_res, 0s
//
// Each sample tick is one request: it passes through the input register and then the
// result register, and one request is taken every cycle while the downstream side
// keeps taking results. That rate rests on the counter update and the readout
// decision, both resolved between those two registers. A stalled result holds in the
// result register; the input side stays ready for as long as the held request can
// move on in the same cycle. After reset the counters hold 0x1111, 0x2222, 0x3333 and
// 0x4444 (masked to the counter width), the previous step sample is zero and the
// readout is idle.

module four_channel_step_dir_counter_readout import fcsd_pkg::*; #(
	parameter int CHANNELS    = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // step_lines, dir_lines, select_n,
	                                              // byte_done, rx_byte, zero pad
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // tx_load, tx_byte, busy_res, zero pad
);

	// Input register: one sample tick waiting for its turn.
	logic     valid_s1;
	in_item_t item_s1;

	// Result register.
	logic     out_valid_q;
	rdo_res_t out_q;

	logic     adv;
	rdo_res_t res;

	logic [CHANNELS-1:0][COUNT_WIDTH-1:0] counts;
	logic [SNAP_W-1:0]                    snap_word;

	// The held request moves on whenever the result register is free or being emptied.
	assign adv           = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1 <= in_item_t'(s_axis_tdata[$bits(in_item_t)-1:0]);
		end
	end

	// Step/direction counters. They are updated from the request in the input register,
	// after the readout has taken its snapshot of the values from before this tick.
	fcsd_counters #(
		.CHANNELS    (CHANNELS),
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_counters (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.step_lines (item_s1.step_lines[CHANNELS-1:0]),
		.dir_lines  (item_s1.dir_lines[CHANNELS-1:0]),
		.counts     (counts)
	);

	// Little-endian snapshot image: bytes 2c and 2c+1 hold the low sixteen bits of
	// channel c. Bits above the counter width and absent channels read as zero.
	for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_snap
		if (c < CHANNELS) begin : g_used
			logic [31:0] ext;
			assign ext                  = 32'(counts[c]);
			assign snap_word[c*16 +: 16] = ext[15:0];
		end else begin : g_absent
			assign snap_word[c*16 +: 16] = '0;
		end
	end

	fcsd_readout u_readout (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.select_n  (item_s1.select_n),
		.byte_done (item_s1.byte_done),
		.rx_byte   (item_s1.rx_byte),
		.snap_word (snap_word),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(out_q);

endmodule

FILE: src/fcsd_counters.sv
`timescale 1ns / 1ps

module fcsd_counters import fcsd_pkg::*; #(
	parameter int CHANNELS    = 4,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  adv,
	input  logic [CHANNELS-1:0]                   step_lines,
	input  logic [CHANNELS-1:0]                   dir_lines,
	output logic [CHANNELS-1:0][COUNT_WIDTH-1:0]  counts
);

	logic [CHANNELS-1:0]                  prev_q;
	logic [CHANNELS-1:0]                  rising;
	logic [CHANNELS-1:0][COUNT_WIDTH-1:0] count_q;

	assign rising = step_lines & ~prev_q;
	assign counts = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (adv) begin
			prev_q <= step_lines;
		end
	end

	for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
		localparam logic [31:0] RST_VAL = COUNT_RST_STEP * (c + 1);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				count_q[c] <= COUNT_WIDTH'(RST_VAL);
			end else if (adv && rising[c]) begin
				// Down-count adds all ones, which wraps the same way.
				count_q[c] <= count_q[c] + (dir_lines[c] ? COUNT_WIDTH'(1) : '1);
			end
		end
	end

endmodule

FILE: src/fcsd_readout.sv
`timescale 1ns / 1ps

module fcsd_readout import fcsd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              select_n,
	input  logic              byte_done,
	input  logic [7:0]        rx_byte,
	input  logic [SNAP_W-1:0] snap_word,
	output rdo_res_t          res
);

	logic [SEND_IDX_W-1:0] idx_q;
	logic [SEND_IDX_W-1:0] idx_next;
	logic [7:0]            snap_q [SNAP_BYTES];
	logic                  take_snap;

	always_comb begin
		res       = '0;
		idx_next  = idx_q;
		take_snap = 1'b0;
		if (idx_q != '0) begin
			if (byte_done) begin
				if (rx_byte == STOP_BYTE) begin
					idx_next = '0;
				end else begin
					res.tx_byte = snap_q[idx_q[SNAP_IDX_W-1:0]];
					res.tx_load = 1'b1;
					// Wrap of the index back to zero ends the transfer.
					idx_next    = idx_q + SEND_IDX_W'(1);
				end
			end
		end else if (!select_n) begin
			take_snap   = 1'b1;
			res.tx_byte = snap_word[7:0];
			res.tx_load = 1'b1;
			idx_next    = SEND_IDX_W'(1);
		end
		res.busy_res = (idx_next != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (adv) begin
			idx_q <= idx_next;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && take_snap) begin
			for (int b = 0; b < SNAP_BYTES; b++) begin
				snap_q[b] <= snap_word[b*8 +: 8];
			end
		end
	end

endmodule

FILE: src/fcsd_checker.sv
`timescale 1ns / 1ps

module fcsd_checker import fcsd_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

	// A stalled result holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result changed while stalled");

	// While the result side is taking results the input side never stalls.
	a_ready_follow: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while results are being taken");

	// Without a load the byte field is zero.
	a_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[8:1] == 8'h00))
		else $error("byte field set without a load");

	// With the result register empty the input side must take a request.
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with result register empty");

endmodule

bind four_channel_step_dir_counter_readout fcsd_checker u_fcsd_checker (.*);
